// File: design/swms_pkg.sv
`timescale 1ns / 1ps

package swms_pkg;

    // Fixed field widths of the stream and the register
    localparam int SAMPLE_W    = 24;
    localparam int TAG_W       = 32;
    localparam int MEAN_W      = 24;
    localparam int STDEV_W     = 23;
    localparam int CFG_W       = 7;
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 80;

    localparam logic [CFG_W-1:0]   CFG_RESET = 7'd16;
    localparam logic [STDEV_W-1:0] STDEV_MAX = 23'd8388607;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_UPDATE,
        ST_PRODUCT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic rd;
        logic sq;
        logic upd;
        logic prod;
        logic div_start;
        logic sqrt_start;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } status_t;

endpackage

// File: design/sliding_window_mean_stdev_top.sv
`timescale 1ns / 1ps
// Flow: a taken sample goes through read, square and update; if it completes no window the
// block then returns to idle, otherwise it goes on through the products, the bit-serial mean
// and variance divides, the bit-serial square root and the output load before m_tvalid rises.
// Requests: one at a time; the next is taken once the result is in the output register,
// even if that result still waits for m_tready.
// Reset: rst_n is asynchronous, active low; window returns to 16 and the series empties.

module sliding_window_mean_stdev_top
    import swms_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Window size register; any write restarts the series
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_data,

    // Input requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [23:0] sample, [55:24] date_tag
    input  logic                   s_tuser,   // [0] start_of_series

    // Result requests
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // [31:0] out_date_tag, [55:32] window_mean,
                                              // [78:56] window_stdev, [79] zero
);

    cmd_t                       cmd;
    status_t                    status;

    logic signed [SAMPLE_W-1:0] in_sample;
    logic [TAG_W-1:0]           in_tag;
    logic [TAG_W-1:0]           out_tag;
    logic signed [MEAN_W-1:0]   out_mean;
    logic [STDEV_W-1:0]         out_stdev;

    // Unpack the input request
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_tag    = s_tdata[SAMPLE_W+TAG_W-1:SAMPLE_W];

    // Controller: walks read, square, update, products, divides, root, output load
    swms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Datapath: sample ring, running sums, dividers, square root, output register
    swms_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_sample (in_sample),
        .in_tag    (in_tag),
        .in_start  (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tag   (out_tag),
        .out_mean  (out_mean),
        .out_stdev (out_stdev)
    );

    // Pack the result request; pad the top bit with zero
    assign m_tdata = {1'b0, out_stdev, out_mean, out_tag};

endmodule

// File: design/swms_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module swms_div
    import swms_pkg::*;
#(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// File: design/swms_sqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one root bit per cycle.
module swms_sqrt
    import swms_pkg::*;
#(
    parameter int IN_W = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [IN_W-1:0]         operand,
    output logic                    busy,
    output logic [(IN_W+1)/2-1:0]   root
);

    localparam int RT_W  = (IN_W + 1) / 2;
    localparam int OP_W  = 2 * RT_W;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OP_W-1:0]  op_reg;
    logic [RT_W:0]    rem_reg;
    logic [RT_W-1:0]  root_reg;

    logic [RT_W+2:0]  cur;
    logic [RT_W+2:0]  trial;
    logic [RT_W+2:0]  diff;
    logic             ge;

    always_comb
    begin
        cur   = {rem_reg, op_reg[OP_W-1:OP_W-2]};
        trial = {1'b0, root_reg, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RT_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= OP_W'(operand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[OP_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[RT_W:0] : cur[RT_W:0];
            root_reg <= {root_reg[RT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: design/swms_datapath.sv
`timescale 1ns / 1ps

module swms_datapath
    import swms_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic [TAG_W-1:0]           in_tag,
    input  logic                       in_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [TAG_W-1:0]           out_tag,
    output logic signed [MEAN_W-1:0]   out_mean,
    output logic [STDEV_W-1:0]         out_stdev
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IX_W  = CNT_W + 1;
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int MAG_W = SUM_W - 1;
    localparam int SQS_W = 2 * SAMPLE_W - 1;
    localparam int SQ_W  = SQS_W - 1 + CNT_W;
    localparam int NUM_W = CNT_W + SQ_W;
    localparam int NN_W  = 2 * CNT_W;
    localparam int RT_W  = (NUM_W + 1) / 2;
    localparam int EW    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [SAMPLE_W-1:0]        ring_mem [WINDOW_MAX];

    logic [CFG_W-1:0]           win_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic [SQS_W-1:0]           new_sq_reg;
    logic [SQS_W-1:0]           old_sq_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           nq_reg;
    logic [NUM_W-1:0]           s2_reg;
    logic [NN_W-1:0]            nn_reg;

    logic                       out_valid_reg;
    logic [TAG_W-1:0]           out_tag_reg;
    logic signed [MEAN_W-1:0]   out_mean_reg;
    logic [STDEV_W-1:0]         out_stdev_reg;

    logic [EW-1:0]              w_ext;
    logic [CNT_W-1:0]           n;
    logic [IX_W-1:0]            wp_ext;
    logic [IX_W-1:0]            n_ext;
    logic [IX_W-1:0]            idx_full;
    logic [PTR_W-1:0]           old_idx;
    logic [PTR_W-1:0]           wp_next;
    logic                       restart;

    logic signed [2*SAMPLE_W-1:0] new_prod;
    logic signed [2*SAMPLE_W-1:0] old_prod;
    logic signed [SUM_W-1:0]    neg_sum;
    logic [MAG_W-1:0]           mag_c;
    logic [NUM_W-1:0]           var_num;

    logic                       mean_busy;
    logic                       var_busy;
    logic                       sqrt_busy;
    logic [MAG_W-1:0]           mean_quo;
    logic [NUM_W-1:0]           var_quo;
    logic [RT_W-1:0]            root;
    logic [MEAN_W-1:0]          mean_lo;
    logic signed [MEAN_W-1:0]   mean_c;
    logic [STDEV_W-1:0]         stdev_c;

    // Effective window: zero acts as one, above the ring depth clamps
    always_comb
    begin
        w_ext = EW'(win_reg);
        if (w_ext == '0)
        begin
            n = CNT_W'(1);
        end
        else if (w_ext > EW'(WINDOW_MAX))
        begin
            n = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            n = CNT_W'(w_ext);
        end
    end

    // Ring slot of the sample that leaves the window
    always_comb
    begin
        wp_ext = IX_W'(wp_reg);
        n_ext  = IX_W'(n);
        if (wp_ext >= n_ext)
        begin
            idx_full = wp_ext - n_ext;
        end
        else
        begin
            idx_full = wp_ext + IX_W'(WINDOW_MAX) - n_ext;
        end
        old_idx = idx_full[PTR_W-1:0];
        wp_next = (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + PTR_W'(1);
    end

    assign restart  = cfg_we || (cmd.take && in_start);
    assign new_prod = (2*SAMPLE_W)'(sample_reg) * (2*SAMPLE_W)'(sample_reg);
    assign old_prod = (2*SAMPLE_W)'(old_reg) * (2*SAMPLE_W)'(old_reg);
    assign neg_sum  = -sum_reg;
    assign mag_c    = sum_reg[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[MAG_W-1:0];
    assign var_num  = nq_reg - s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= CFG_RESET;
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg <= cfg_data;
            end
            if (restart)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
            end
            else if (cmd.upd)
            begin
                wp_reg <= wp_next;
                if (fill_reg >= n)
                begin
                    sum_reg <= sum_reg + SUM_W'(sample_reg) - SUM_W'(old_reg);
                    sq_reg  <= sq_reg + SQ_W'(new_sq_reg) - SQ_W'(old_sq_reg);
                end
                else
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                    sum_reg  <= sum_reg + SUM_W'(sample_reg);
                    sq_reg   <= sq_reg + SQ_W'(new_sq_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            old_reg <= ring_mem[old_idx];
        end
        if (cmd.upd)
        begin
            ring_mem[wp_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= in_sample;
            tag_reg    <= in_tag;
        end
        if (cmd.sq)
        begin
            new_sq_reg <= new_prod[SQS_W-1:0];
            old_sq_reg <= old_prod[SQS_W-1:0];
        end
        if (cmd.prod)
        begin
            mag_reg <= mag_c;
            neg_reg <= sum_reg[SUM_W-1];
            nq_reg  <= NUM_W'(n) * NUM_W'(sq_reg);
            s2_reg  <= NUM_W'(mag_c) * NUM_W'(mag_c);
            nn_reg  <= NN_W'(n) * NN_W'(n - CNT_W'(1));
        end
    end

    swms_div #(
        .NUM_W (MAG_W),
        .DEN_W (CNT_W)
    ) u_mean_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (mag_reg),
        .den   (n),
        .busy  (mean_busy),
        .quo   (mean_quo)
    );

    swms_div #(
        .NUM_W (NUM_W),
        .DEN_W (NN_W)
    ) u_var_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (var_num),
        .den   (nn_reg),
        .busy  (var_busy),
        .quo   (var_quo)
    );

    swms_sqrt #(
        .IN_W (NUM_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (var_quo),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // Apply the sign to the mean; force zero deviation for a window of one
    always_comb
    begin
        mean_lo = mean_quo[MEAN_W-1:0];
        mean_c  = neg_reg ? (MEAN_W'(0) - mean_lo) : mean_lo;
        if (n < CNT_W'(2))
        begin
            stdev_c = '0;
        end
        else if (|root[RT_W-1:STDEV_W])
        begin
            stdev_c = STDEV_MAX;
        end
        else
        begin
            stdev_c = root[STDEV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_tag_reg   <= tag_reg;
            out_mean_reg  <= mean_c;
            out_stdev_reg <= stdev_c;
        end
    end

    assign status.emit      = ((IX_W'(fill_reg) + IX_W'(1)) >= IX_W'(n));
    assign status.div_busy  = mean_busy || var_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_mean  = out_mean_reg;
    assign out_stdev = out_stdev_reg;

endmodule

// File: design/swms_ctrl.sv
`timescale 1ns / 1ps

module swms_ctrl
    import swms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:       state_next = ST_SQUARE;
            ST_SQUARE:     state_next = ST_UPDATE;
            ST_UPDATE:     state_next = status.emit ? ST_PRODUCT : ST_IDLE;
            ST_PRODUCT:    state_next = ST_DIV_START;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SQRT_START;
                end
            end
            ST_SQRT_START: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_READ:       cmd.rd         = 1'b1;
            ST_SQUARE:     cmd.sq         = 1'b1;
            ST_UPDATE:     cmd.upd        = 1'b1;
            ST_PRODUCT:    cmd.prod       = 1'b1;
            ST_DIV_START:  cmd.div_start  = 1'b1;
            ST_SQRT_START: cmd.sqrt_start = 1'b1;
            ST_FINISH:     cmd.out_load   = status.out_free;
            default:       cmd            = '0;
        endcase
    end

endmodule

// File: design/swms_checker.sv
`timescale 1ns / 1ps

module swms_checker
    import swms_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Drop ready after a request is taken: one request in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready stayed high after a request was taken");

    // A new result never appears right after an input is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready, 1))
        else $error("result appeared one cycle after input accept");

endmodule

bind sliding_window_mean_stdev_top swms_checker u_swms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_sliding_window_mean_stdev_top.sv
`timescale 1ns / 1ps

module tb_sliding_window_mean_stdev_top;
    import swms_pkg::*;

    localparam int WIN_MAX       = 64;
    localparam int SETTLE_CYCLES = 150;     // covers the slowest request
    localparam int WATCHDOG_MAX  = 4000;    // idle cycles before the run is declared hung
    localparam int LONG_HOLD     = 400;     // length of the forced receiver hold-off
    localparam int HOLD_AFTER    = 300;     // results seen before the hold-off starts
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 83;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;

    // One input request: a sample, its date and the restart flag
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [TAG_W-1:0]           tag;
        logic                       restart;
    } sample_req_t;

    // One expected result request
    typedef struct {
        logic [TAG_W-1:0]         tag;
        logic signed [MEAN_W-1:0] mean;
        logic [STDEV_W-1:0]       stdev;
    } window_stats_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;   // [23:0] sample, [55:24] date_tag
    logic                   s_tuser;   // [0] start_of_series
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;   // [31:0] out_date_tag, [55:32] window_mean,
                                       // [78:56] window_stdev, [79] zero

    sliding_window_mean_stdev_top #(
        .WINDOW_MAX (WIN_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Requests waiting for the driver, and window statistics waiting for the monitor
    sample_req_t   pending_reqs[$];
    window_stats_t expected_stats[$];

    int err_count;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;

    // Shadow copy of the block's window state
    logic signed [SAMPLE_W-1:0] ring_samples[WIN_MAX];
    int unsigned                ring_wr;
    int unsigned                ring_fill;
    longint                     run_sum;
    longint unsigned            run_sq_sum;
    logic [CFG_W-1:0]           win_cfg;

    logic [TAG_W-1:0] next_tag;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, exp_val, got_val);
        err_count++;
    endtask

    task automatic clear_window();
        foreach (ring_samples[i])
            ring_samples[i] = '0;
        ring_wr    = 0;
        ring_fill  = 0;
        run_sum    = 0;
        run_sq_sum = 0;
    endtask

    function automatic int unsigned window_length(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WIN_MAX)
            return WIN_MAX;
        return w;
    endfunction

    // Floor square root, one result bit per step from the top
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advance the shadow window by one sample and queue the statistics it yields
    task automatic predict_window_stats(input sample_req_t r);
        int unsigned     n;
        int unsigned     old_idx;
        longint          s;
        longint          old_s;
        longint          mean;
        longint unsigned mag;
        logic [127:0]    spread;
        logic [127:0]    divisor;
        logic [127:0]    variance;
        logic [63:0]     root;
        window_stats_t   st;

        n = window_length(win_cfg);
        if (r.restart)
            clear_window();
        s = r.sample;
        if (ring_fill >= n)
        begin
            old_idx = (ring_wr + WIN_MAX - n) % WIN_MAX;
            old_s   = ring_samples[old_idx];
            run_sum    -= old_s;
            run_sq_sum -= old_s * old_s;
        end
        else
            ring_fill++;
        run_sum    += s;
        run_sq_sum += s * s;
        ring_samples[ring_wr] = r.sample;
        ring_wr = (ring_wr + 1) % WIN_MAX;

        if (ring_fill < n)
            return;

        mean     = run_sum / longint'(n);
        st.tag   = r.tag;
        st.mean  = mean[MEAN_W-1:0];
        st.stdev = '0;
        if (n >= 2)
        begin
            mag      = (run_sum < 0) ? -run_sum : run_sum;
            spread   = 128'(n) * 128'(run_sq_sum) - 128'(mag) * 128'(mag);
            divisor  = 128'(n) * 128'(n - 1);
            variance = spread / divisor;
            root     = (variance[127:64] != 0) ? 64'hFFFF_FFFF : floor_sqrt(variance[63:0]);
            st.stdev = (root > STDEV_MAX) ? STDEV_MAX : root[STDEV_W-1:0];
        end
        expected_stats = {expected_stats, st};
    endtask

    // Driver: offer the next pending request, idling at random; predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_window_stats('{sample: s_tdata[SAMPLE_W-1:0],
                                       tag: s_tdata[TDATA_IN_W-1:SAMPLE_W],
                                       restart: s_tuser});
            // Hold the current request until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {r.tag, r.sample};
                    s_tuser  <= r.restart;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the block fills and stalls
    int  hold_left;
    bit  hold_done;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result request with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            window_stats_t st;
            results_seen++;
            if (expected_stats.size() == 0)
                report_mismatch("result with nothing expected, tdata", '0, m_tdata[63:0]);
            else
            begin
                st = expected_stats.pop_front();
                if (m_tdata[31:0] !== st.tag)
                    report_mismatch("out_date_tag", st.tag, m_tdata[31:0]);
                if (m_tdata[55:32] !== st.mean)
                    report_mismatch("window_mean", st.mean, m_tdata[55:32]);
                if (m_tdata[78:56] !== st.stdev)
                    report_mismatch("window_stdev", st.stdev, m_tdata[78:56]);
            end
        end
    end

    // Watchdog: end the run if no request moves for too long
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_request(input logic signed [SAMPLE_W-1:0] sample,
                                 input logic [TAG_W-1:0] tag, input logic restart);
        pending_reqs = {pending_reqs, sample_req_t'{sample: sample, tag: tag, restart: restart}};
    endtask

    // Write the window register while the block is idle; the series restarts
    task automatic write_window(input logic [CFG_W-1:0] w);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we   <= 1'b0;
        win_cfg = w;
        clear_window();
    endtask

    // Wait for all requests to go in and all results to come out, then let the block settle
    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mix of full-range noise, small negative values, rails, and a slowly drifting series
    logic signed [SAMPLE_W-1:0] drift_level;

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return raw[SAMPLE_W-1:0];
            4:       return $signed(raw[11:0]) - 24'sd2048;
            default:
            begin
                drift_level = drift_level + $signed(raw[9:0]) - 24'sd512;
                return drift_level;
            end
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(19) == 0)
            next_tag = $urandom();
        else
            next_tag = next_tag + $urandom_range(1, 86400);
        return next_tag;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] phase_win[RANDOM_PHASES];
        logic [CFG_W-1:0] w;

        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        err_count     = 0;
        results_seen  = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 21;
        recv_idle_pct = 59;
        next_tag      = 32'd1000;
        drift_level   = '0;
        win_cfg       = CFG_RESET;
        clear_window();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the reset window of 16, rails and tag extremes; two results
        queue_request(SAMPLE_MAX, 32'h0000_0000, 1'b0);
        queue_request(SAMPLE_MIN, 32'hFFFF_FFFF, 1'b0);
        queue_request(24'sd0, 32'h0000_0001, 1'b0);
        queue_request(-24'sd1, 32'h8000_0000, 1'b0);
        for (int i = 0; i < 13; i++)
            queue_request(pick_sample(), pick_tag(), 1'b0);
        drain_and_settle();

        // Window of one: mean is the sample, deviation is zero
        write_window(7'd1);
        queue_request(SAMPLE_MAX, 32'hFFFF_FFFF, 1'b0);
        queue_request(SAMPLE_MIN, 32'h0000_0000, 1'b1);
        queue_request(-24'sd1, 32'h1234_5678, 1'b0);
        drain_and_settle();

        // Window size zero acts as a window of one
        write_window(7'd0);
        queue_request(24'sd1, 32'h0000_0010, 1'b0);
        queue_request(SAMPLE_MIN, 32'h0000_0011, 1'b0);
        drain_and_settle();

        // Rails alternating in a window of two saturate the deviation; restart mid-series
        write_window(7'd2);
        queue_request(SAMPLE_MIN, 32'h0000_0020, 1'b0);
        queue_request(SAMPLE_MAX, 32'h0000_0021, 1'b0);
        queue_request(SAMPLE_MIN, 32'h0000_0022, 1'b1);
        queue_request(SAMPLE_MAX, 32'h0000_0023, 1'b0);
        drain_and_settle();

        // Random phases over several window settings, extremes among them
        phase_win = '{7'd64, 7'd127, 7'd3, 7'd1, 7'd0, 7'd2, 7'd0, 7'd7, 7'd64, 7'd0};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 59;
            end
            else if (p < 7)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = phase_win[p];
            if (p == 6 || p == 9)
                w = CFG_W'($urandom_range(4, 127));
            write_window(w);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_request(pick_sample(), pick_tag(), $urandom_range(99) < 3);
            drain_and_settle();
        end

        if (err_count == 0 && expected_stats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
